// ----- sv/hrcg_pkg.sv -----
`default_nettype none
package hrcg_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int COORD_BITS  = 32;
    localparam int RADIUS_BITS = 4;
    localparam logic [RADIUS_BITS-1:0] MAX_RADIUS = RADIUS_BITS'(10);
    localparam int CMD_DEPTH   = 2;

    // one queued request, apart from its coordinates
    typedef struct packed {
        logic                   single;   // emit one cell only (zero radius or error)
        logic                   err;
        logic                   parity;
        logic [RADIUS_BITS-1:0] radius;
    } t_cmd_ctl;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    typedef enum logic [5:0] {
        SIDE_0 = 6'b000001,
        SIDE_1 = 6'b000010,
        SIDE_2 = 6'b000100,
        SIDE_3 = 6'b001000,
        SIDE_4 = 6'b010000,
        SIDE_5 = 6'b100000
    } t_side;

endpackage
`default_nettype wire

// ----- sv/hrcg_front.sv -----
`default_nettype none
module hrcg_front #(
    parameter int COORD_BITS = hrcg_pkg::COORD_BITS
) (
    input  wire logic signed [hrcg_pkg::FIELD_BITS-1:0]  i_origin_x,
    input  wire logic signed [hrcg_pkg::FIELD_BITS-1:0]  i_origin_y,
    input  wire logic        [hrcg_pkg::RADIUS_BITS-1:0] i_radius,
    output hrcg_pkg::t_cmd_ctl                           o_ctl,
    output logic             [COORD_BITS-1:0]            o_x,
    output logic             [COORD_BITS-1:0]            o_y
);

    logic signed [63:0]           ext_x;
    logic signed [63:0]           ext_y;
    logic        [COORD_BITS-1:0] org_x;
    logic        [COORD_BITS-1:0] org_y;
    logic                         is_zero;
    logic                         is_err;

    // bring the 32-bit fields to the internal coordinate width
    assign ext_x = 64'(i_origin_x);
    assign ext_y = 64'(i_origin_y);
    assign org_x = ext_x[COORD_BITS-1:0];
    assign org_y = ext_y[COORD_BITS-1:0];

    assign is_zero = (i_radius == '0);
    assign is_err  = (i_radius > hrcg_pkg::MAX_RADIUS);

    always_comb begin
        o_ctl.single = is_zero | is_err;
        o_ctl.err    = is_err;
        o_ctl.parity = org_y[0];
        o_ctl.radius = i_radius;
        if (is_err) begin
            o_x = '0;
            o_y = '0;
        end else if (is_zero) begin
            o_x = org_x;
            o_y = org_y;
        end else begin
            // walk starts radius cells to the left
            o_x = org_x - COORD_BITS'(i_radius);
            o_y = org_y;
        end
    end

endmodule
`default_nettype wire

// ----- sv/hrcg_cmd_queue.sv -----
`default_nettype none
module hrcg_cmd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hrcg_pkg::CMD_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_vld,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == CNT_BITS'(DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_vld;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/hrcg_back.sv -----
`default_nettype none
module hrcg_back #(
    parameter int COORD_BITS = hrcg_pkg::COORD_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cmd_vld,
    input  wire hrcg_pkg::t_cmd_ctl                     i_cmd_ctl,
    input  wire logic        [COORD_BITS-1:0]           i_cmd_x,
    input  wire logic        [COORD_BITS-1:0]           i_cmd_y,
    output logic                                        o_cmd_pop,
    input  wire logic                                   i_pop,
    output logic                                        o_empty,
    output logic signed      [hrcg_pkg::FIELD_BITS-1:0] o_cell_x,
    output logic signed      [hrcg_pkg::FIELD_BITS-1:0] o_cell_y,
    output logic                                        o_last,
    output logic                                        o_radius_error
);

    localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

    hrcg_pkg::t_state                      r_state, n_state;
    hrcg_pkg::t_side                       r_side, n_side;
    logic [hrcg_pkg::RADIUS_BITS-1:0]      r_step, n_step;
    logic [hrcg_pkg::RADIUS_BITS-1:0]      r_rad, n_rad;
    logic                                  r_par, n_par;
    logic [COORD_BITS-1:0]                 r_x, n_x;
    logic [COORD_BITS-1:0]                 r_y, n_y;

    logic                                  r_out_vld, n_out_vld;
    logic [COORD_BITS-1:0]                 r_out_x, n_out_x;
    logic [COORD_BITS-1:0]                 r_out_y, n_out_y;
    logic                                  r_out_last, n_out_last;
    logic                                  r_out_err, n_out_err;

    logic                                  adv;
    logic                                  out_load;
    logic                                  step_end;
    logic                                  ring_end;
    logic                                  par_t;
    logic signed [COORD_BITS-1:0]          sx;
    logic signed [COORD_BITS-1:0]          sy;
    logic signed [63:0]                    ext_x;
    logic signed [63:0]                    ext_y;

    // output register frees up when empty or being taken this cycle
    assign adv      = ~r_out_vld | i_pop;
    assign step_end = (r_step == r_rad - 1'b1);
    assign ring_end = (r_side == hrcg_pkg::SIDE_5) & step_end;
    assign par_t    = ~r_par;

    always_comb begin
        n_state    = r_state;
        n_side     = r_side;
        n_step     = r_step;
        n_rad      = r_rad;
        n_par      = r_par;
        n_x        = r_x;
        n_y        = r_y;
        n_out_x    = r_out_x;
        n_out_y    = r_out_y;
        n_out_last = r_out_last;
        n_out_err  = r_out_err;
        out_load   = 1'b0;
        o_cmd_pop  = 1'b0;

        unique case (r_state)
            hrcg_pkg::ST_IDLE: begin
                if (i_cmd_vld && adv) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd_ctl.single) begin
                        out_load   = 1'b1;
                        n_out_x    = i_cmd_x;
                        n_out_y    = i_cmd_y;
                        n_out_last = 1'b1;
                        n_out_err  = i_cmd_ctl.err;
                    end else begin
                        n_state = hrcg_pkg::ST_WALK;
                        n_side  = hrcg_pkg::SIDE_0;
                        n_step  = '0;
                        n_rad   = i_cmd_ctl.radius;
                        n_par   = i_cmd_ctl.parity;
                        n_x     = i_cmd_x;
                        n_y     = i_cmd_y;
                    end
                end
            end
            hrcg_pkg::ST_WALK: begin
                if (adv) begin
                    out_load   = 1'b1;
                    n_out_x    = r_x;
                    n_out_y    = r_y;
                    n_out_last = ring_end;
                    n_out_err  = 1'b0;
                    n_step     = step_end ? '0 : r_step + 1'b1;
                    if (ring_end) begin
                        n_state = hrcg_pkg::ST_IDLE;
                    end
                    unique case (r_side)
                        hrcg_pkg::SIDE_0: begin
                            n_x = r_x + COORD_BITS'(r_par);
                            n_y = r_y + ONE;
                            n_par = par_t;
                            if (step_end) n_side = hrcg_pkg::SIDE_1;
                        end
                        hrcg_pkg::SIDE_1: begin
                            n_x = r_x + ONE;
                            if (step_end) n_side = hrcg_pkg::SIDE_2;
                        end
                        hrcg_pkg::SIDE_2: begin
                            n_x = r_x + COORD_BITS'(r_par);
                            n_y = r_y - ONE;
                            n_par = par_t;
                            if (step_end) n_side = hrcg_pkg::SIDE_3;
                        end
                        hrcg_pkg::SIDE_3: begin
                            // parity flips before it is used on this side
                            n_par = par_t;
                            n_x = r_x - COORD_BITS'(par_t);
                            n_y = r_y - ONE;
                            if (step_end) n_side = hrcg_pkg::SIDE_4;
                        end
                        hrcg_pkg::SIDE_4: begin
                            n_x = r_x - ONE;
                            if (step_end) n_side = hrcg_pkg::SIDE_5;
                        end
                        hrcg_pkg::SIDE_5: begin
                            n_par = par_t;
                            n_x = r_x - COORD_BITS'(par_t);
                            n_y = r_y + ONE;
                            if (step_end) n_side = hrcg_pkg::SIDE_0;
                        end
                        default: begin
                            n_side = hrcg_pkg::SIDE_0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = hrcg_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hrcg_pkg::ST_IDLE;
            r_side    <= hrcg_pkg::SIDE_0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_side    <= n_side;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad      <= n_rad;
        r_par      <= n_par;
        r_x        <= n_x;
        r_y        <= n_y;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
        r_out_err  <= n_out_err;
    end

    // sign-extend from the coordinate width, then fit the 32-bit field
    assign sx    = r_out_x;
    assign sy    = r_out_y;
    assign ext_x = 64'(sx);
    assign ext_y = 64'(sy);

    assign o_empty        = ~r_out_vld;
    assign o_cell_x       = ext_x[hrcg_pkg::FIELD_BITS-1:0];
    assign o_cell_y       = ext_y[hrcg_pkg::FIELD_BITS-1:0];
    assign o_last         = r_out_last;
    assign o_radius_error = r_out_err;

endmodule
`default_nettype wire

// ----- sv/hex_ring_coordinate_generator.sv -----
`default_nettype none
// Channel   Direction  Handshake              Fields
// request   in         push / full            i_origin_x, i_origin_y, i_radius
// cell      out        empty / pop            o_cell_x, o_cell_y, o_last, o_radius_error
//
// A ring of radius r gives 6*r cells, one per cycle while the receiver pops, after a
// step to load the walker; radius zero or out of range gives a single cell.
// The walker in the back end sets the rate; a two-entry request queue lets the
// front accept while a ring is in progress. Cells wait in a single output register.
// Reset (synchronous, active low) empties the queue and the output register.
module hex_ring_coordinate_generator #(
    parameter int COORD_BITS = hrcg_pkg::COORD_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic signed [hrcg_pkg::FIELD_BITS-1:0]  i_origin_x,
    input  wire logic signed [hrcg_pkg::FIELD_BITS-1:0]  i_origin_y,
    input  wire logic        [hrcg_pkg::RADIUS_BITS-1:0] i_radius,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed      [hrcg_pkg::FIELD_BITS-1:0] o_cell_x,
    output logic signed      [hrcg_pkg::FIELD_BITS-1:0] o_cell_y,
    output logic                                        o_last,
    output logic                                        o_radius_error
);

    localparam int CTL_BITS = $bits(hrcg_pkg::t_cmd_ctl);
    localparam int Q_WIDTH  = CTL_BITS + 2 * COORD_BITS;

    hrcg_pkg::t_cmd_ctl    f_ctl;
    logic [COORD_BITS-1:0] f_x;
    logic [COORD_BITS-1:0] f_y;
    logic [Q_WIDTH-1:0]    q_wdata;
    logic [Q_WIDTH-1:0]    q_rdata;
    logic                  q_vld;
    logic                  q_pop;
    hrcg_pkg::t_cmd_ctl    b_ctl;
    logic [COORD_BITS-1:0] b_x;
    logic [COORD_BITS-1:0] b_y;

    hrcg_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_radius   (i_radius),
        .o_ctl      (f_ctl),
        .o_x        (f_x),
        .o_y        (f_y)
    );

    assign q_wdata = {f_ctl, f_x, f_y};

    hrcg_cmd_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (hrcg_pkg::CMD_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_rdata)
    );

    assign b_ctl = hrcg_pkg::t_cmd_ctl'(q_rdata[Q_WIDTH-1 -: CTL_BITS]);
    assign b_x   = q_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign b_y   = q_rdata[COORD_BITS-1:0];

    hrcg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_vld      (q_vld),
        .i_cmd_ctl      (b_ctl),
        .i_cmd_x        (b_x),
        .i_cmd_y        (b_y),
        .o_cmd_pop      (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_cell_x       (o_cell_x),
        .o_cell_y       (o_cell_y),
        .o_last         (o_last),
        .o_radius_error (o_radius_error)
    );

endmodule
`default_nettype wire

// ----- tb/hex_ring_coordinate_generator_test.sv -----
`default_nettype none
module hex_ring_coordinate_generator_test;

    localparam int FB = hrcg_pkg::FIELD_BITS;
    localparam int CB = hrcg_pkg::COORD_BITS;
    localparam int RB = hrcg_pkg::RADIUS_BITS;
    localparam int N_RANDOM = 291;
    localparam int SQUEEZE_CYCLES = 400;

    // one request, with the single expected cell typed in where it is obvious
    typedef struct packed {
        logic signed [FB-1:0] ox;
        logic signed [FB-1:0] oy;
        logic [RB-1:0]        r;
        logic                 typed;
        logic signed [FB-1:0] ex;
        logic signed [FB-1:0] ey;
        logic                 eerr;
    } t_req;

    typedef struct packed {
        logic signed [FB-1:0] cx;
        logic signed [FB-1:0] cy;
        logic                 is_last;
        logic                 is_err;
    } t_spot;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic signed [FB-1:0] i_origin_x = '0;
    logic signed [FB-1:0] i_origin_y = '0;
    logic [RB-1:0] i_radius = '0;
    logic full, empty;
    logic signed [FB-1:0] o_cell_x, o_cell_y;
    logic o_last, o_radius_error;

    t_spot ring_due[$];
    int err_count = 0;
    int cells_seen = 0;
    int reqs_sent = 0;
    int bad_radii = 0;
    int full_stalls = 0;
    bit calm = 1'b0;
    bit squeeze_req = 1'b0;

    localparam int N_DIR = 19;
    t_req directed [N_DIR] = '{
        '{32'h00000000, 32'h00000000, 4'd0,  1'b1, 32'h00000000, 32'h00000000, 1'b0},
        '{32'h7FFFFFFF, 32'h80000000, 4'd0,  1'b1, 32'h7FFFFFFF, 32'h80000000, 1'b0},
        '{32'h80000000, 32'h7FFFFFFF, 4'd0,  1'b1, 32'h80000000, 32'h7FFFFFFF, 1'b0},
        '{32'h7FFFFFFF, 32'h00000001, 4'd0,  1'b1, 32'h7FFFFFFF, 32'h00000001, 1'b0},
        '{32'h00000005, -32'sd3,      4'd15, 1'b1, 32'h00000000, 32'h00000000, 1'b1},
        '{32'hFFFFFFFF, 32'hFFFFFFFF, 4'd11, 1'b1, 32'h00000000, 32'h00000000, 1'b1},
        '{32'h00000002, 32'h00000003, 4'd12, 1'b1, 32'h00000000, 32'h00000000, 1'b1},
        '{32'h00000000, 32'h00000000, 4'd1,  1'b0, '0, '0, 1'b0},
        '{32'h00000000, 32'h00000001, 4'd1,  1'b0, '0, '0, 1'b0},
        '{32'h00000003, 32'h00000004, 4'd2,  1'b0, '0, '0, 1'b0},
        '{-32'sd7,      -32'sd5,      4'd3,  1'b0, '0, '0, 1'b0},
        '{32'h00000064, -32'sd100,    4'd4,  1'b0, '0, '0, 1'b0},
        '{32'h12345678, 32'h0AAAAAAA, 4'd6,  1'b0, '0, '0, 1'b0},
        '{32'hFFFF0000, 32'h00005555, 4'd7,  1'b0, '0, '0, 1'b0},
        '{32'h00000001, 32'h00000002, 4'd8,  1'b0, '0, '0, 1'b0},
        '{32'h00000000, 32'h7FFFFFFE, 4'd9,  1'b0, '0, '0, 1'b0},
        '{32'h80000000, 32'h00000000, 4'd10, 1'b0, '0, '0, 1'b0},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 4'd10, 1'b0, '0, '0, 1'b0},
        '{32'h80000000, 32'h80000000, 4'd10, 1'b0, '0, '0, 1'b0}
    };

    hex_ring_coordinate_generator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_radius       (i_radius),
        .empty          (empty),
        .pop            (pop),
        .o_cell_x       (o_cell_x),
        .o_cell_y       (o_cell_y),
        .o_last         (o_last),
        .o_radius_error (o_radius_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #(64'd600000 * 20);
        $display("DONE: errors detected");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [FB-1:0] got,
                                 input logic [FB-1:0] want);
        err_count++;
        $display("MISMATCH cell %0d %s: got %h expected %h", cells_seen, what, got, want);
    endtask

    // expected cells of one ring, in walk order
    function automatic void walk_ring(input logic signed [FB-1:0] ox,
                                      input logic signed [FB-1:0] oy,
                                      input logic [RB-1:0] r);
        logic [CB-1:0] px, py;
        logic par;
        int total, k, side, i;
        if (r == '0) begin
            ring_due.push_back('{ox, oy, 1'b1, 1'b0});
            return;
        end
        if (r > hrcg_pkg::MAX_RADIUS) begin
            ring_due.push_back('{FB'(0), FB'(0), 1'b1, 1'b1});
            return;
        end
        total = 6 * int'(r);
        k = 0;
        px = CB'(ox) - CB'(r);
        py = CB'(oy);
        par = oy[0];
        for (side = 0; side < 6; side++) begin
            for (i = 0; i < int'(r); i++) begin
                ring_due.push_back('{FB'(signed'(px)), FB'(signed'(py)),
                                    k == total - 1, 1'b0});
                k++;
                case (side)
                    0: begin
                        px = px + CB'(par);
                        py = py + CB'(1);
                        par = ~par;
                    end
                    1: px = px + CB'(1);
                    2: begin
                        px = px + CB'(par);
                        py = py - CB'(1);
                        par = ~par;
                    end
                    3: begin
                        par = ~par;
                        px = px - CB'(par);
                        py = py - CB'(1);
                    end
                    4: px = px - CB'(1);
                    default: begin
                        par = ~par;
                        px = px - CB'(par);
                        py = py + CB'(1);
                    end
                endcase
            end
        end
    endfunction

    function automatic logic signed [FB-1:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return FB'($urandom_range(0, 31)) - FB'(16);
            1: return FB'(32'h7FFFFFF0) + FB'($urandom_range(0, 31));
            default: return FB'($urandom);
        endcase
    endfunction

    function automatic t_req random_req();
        t_req q;
        int pick;
        q = '0;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            q.r = RB'($urandom_range(11, 15));
        else if (pick < 12)
            q.r = '0;
        else if (pick < 20)
            q.r = hrcg_pkg::MAX_RADIUS;
        else
            q.r = RB'($urandom_range(1, 9));
        q.ox = pick_coord();
        q.oy = pick_coord();
        return q;
    endfunction

    // present one request, wait for it to be taken, then log what it should produce
    task automatic offer(input t_req q);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 9) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_origin_x <= q.ox;
        i_origin_y <= q.oy;
        i_radius <= q.r;
        do @(posedge i_clk); while (full);
        reqs_sent++;
        if (q.r > hrcg_pkg::MAX_RADIUS)
            bad_radii++;
        if (q.typed)
            ring_due.push_back('{q.ex, q.ey, 1'b1, q.eerr});
        else
            walk_ring(q.ox, q.oy, q.r);
    endtask

    // receiver; a squeeze request holds pop low long enough to back up the input
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                pop <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge i_clk);
            end else begin
                pop <= calm || $urandom_range(0, 99) >= 9;
            end
        end
    end

    always @(posedge i_clk) begin
        t_spot want;
        if (i_rst_n) begin
            if (push && full)
                full_stalls++;
            if (pop && !empty) begin
                if (ring_due.size() == 0) begin
                    flag_mismatch("unexpected cell", o_cell_x, '0);
                end else begin
                    want = ring_due.pop_front();
                    if (o_cell_x !== want.cx)
                        flag_mismatch("cell_x", o_cell_x, want.cx);
                    if (o_cell_y !== want.cy)
                        flag_mismatch("cell_y", o_cell_y, want.cy);
                    if (o_last !== want.is_last)
                        flag_mismatch("last", FB'(o_last), FB'(want.is_last));
                    if (o_radius_error !== want.is_err)
                        flag_mismatch("radius_error", FB'(o_radius_error), FB'(want.is_err));
                end
                cells_seen++;
            end
        end
    end

    initial begin
        int n, j;
        wait (i_rst_n === 1'b1);
        for (j = 0; j < N_DIR; j++)
            offer(directed[j]);
        for (n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 150 && n < 220);
            if (n == 40)
                squeeze_req = 1'b1;
            offer(random_req());
        end
        @(negedge i_clk);
        push <= 1'b0;
        while (ring_due.size() != 0)
            @(posedge i_clk);
        repeat (70) @(posedge i_clk);
        $display("Covered %0d ring requests (%0d with out-of-range radius), %0d cells checked",
                 reqs_sent, bad_radii, cells_seen);
        $display("Input held off by full for %0d cycles in total, including a long receiver stall",
                 full_stalls);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
